// ===== rtl/core/dttm_pkg.sv =====
// Shared types and constants for the duration text to milliseconds parser.
// Used by the parser core and the top level. No dependencies.
`default_nettype none

package dttm_pkg;

    // Parser phase, one-hot
    typedef enum logic [8:0] {
        PH_START     = 9'b000000001,
        PH_MINUS     = 9'b000000010,
        PH_DATE      = 9'b000000100,
        PH_AFTER_D   = 9'b000001000,
        PH_TIME      = 9'b000010000,
        PH_AFTER_H   = 9'b000100000,
        PH_AFTER_MIN = 9'b001000000,
        PH_FRACTION  = 9'b010000000,
        PH_DONE      = 9'b100000000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] duration_ms;
    } t_result;

    localparam int unsigned DIGIT_W = 22;
    localparam int unsigned UNIT_W  = 27;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 22'd4194303;

    localparam logic [UNIT_W-1:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [UNIT_W-1:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [UNIT_W-1:0] MS_PER_MIN  = 27'd60000;
    localparam logic [UNIT_W-1:0] MS_PER_SEC  = 27'd1000;

    localparam logic [DIGIT_W-1:0] LIM_DAY   = 22'd23;
    localparam logic [DIGIT_W-1:0] LIM_HOUR  = 22'd595;
    localparam logic [DIGIT_W-1:0] LIM_MIN   = 22'd35790;
    localparam logic [DIGIT_W-1:0] LIM_SEC   = 22'd2147482;
    localparam logic [DIGIT_W-1:0] LIM_HOUR2 = 22'd23;
    localparam logic [DIGIT_W-1:0] LIM_SIXTY = 22'd59;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Y     = 8'h59;

endpackage

`default_nettype wire

// ===== rtl/core/dttm_byte_if.sv =====
// Valid/ready channel carrying one text byte per request.
// No dependencies.
`default_nettype none

interface dttm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dttm_result_if.sv =====
// Valid/ready channel carrying one parse result per request.
// No dependencies.
`default_nettype none

interface dttm_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] duration_ms;

    modport source (output valid, output status, output duration_ms, input ready);
    modport sink   (input valid, input status, input duration_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dttm_parser.sv =====
// Parser state registers and the per-byte next-state logic.
// Depends on dttm_pkg.
`default_nettype none

module dttm_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output dttm_pkg::t_result o_res
);

    localparam int unsigned DW = dttm_pkg::DIGIT_W;
    localparam int unsigned UW = dttm_pkg::UNIT_W;

    dttm_pkg::t_phase r_phase, n_phase;
    logic [DW-1:0]    r_digit, n_digit;
    logic             r_seen, n_seen;
    logic [1:0]       r_fcnt, n_fcnt;
    logic [31:0]      r_total, n_total;
    logic             r_neg, n_neg;
    logic             r_field, n_field;
    logic [1:0]       r_pend, n_pend;

    logic             numeric, is_dig, is_ss, is_end;
    logic [3:0]       dval;
    logic [DW+3:0]    acc;
    logic [DW-1:0]    acc_sat;

    // field commit request
    logic             want_field;
    logic [DW-1:0]    lim, lim_small;
    dttm_pkg::t_phase ok_phase;
    logic             is_sec;
    logic             add_en;
    logic [UW-1:0]    unit;
    logic [DW+UW-1:0] prod;
    logic [1:0]       st;

    always_comb begin
        is_end  = (i_byte == dttm_pkg::CH_NUL);
        is_dig  = (i_byte >= dttm_pkg::CH_ZERO) && (i_byte <= dttm_pkg::CH_NINE);
        is_ss   = (i_byte == dttm_pkg::CH_PLUS) || (i_byte == dttm_pkg::CH_MINUS) ||
                  (i_byte == dttm_pkg::CH_SPACE) ||
                  ((i_byte >= dttm_pkg::CH_TAB) && (i_byte <= dttm_pkg::CH_CR));
        numeric = (r_phase == dttm_pkg::PH_DATE) || (r_phase == dttm_pkg::PH_TIME) ||
                  (r_phase == dttm_pkg::PH_AFTER_H) || (r_phase == dttm_pkg::PH_AFTER_MIN);
        dval    = i_byte[3:0];
        acc     = {1'b0, r_digit, 3'b000} + {3'b000, r_digit, 1'b0} + {{(DW){1'b0}}, dval};
        acc_sat = (acc > {4'b0000, dttm_pkg::DIGIT_MAX}) ? dttm_pkg::DIGIT_MAX : acc[DW-1:0];
    end

    always_comb begin
        n_phase    = r_phase;
        n_digit    = r_digit;
        n_seen     = r_seen;
        n_fcnt     = r_fcnt;
        n_total    = r_total;
        n_neg      = r_neg;
        n_field    = r_field;
        n_pend     = r_pend;
        want_field = 1'b0;
        lim        = dttm_pkg::LIM_DAY;
        lim_small  = dttm_pkg::LIM_DAY;
        ok_phase   = dttm_pkg::PH_DONE;
        is_sec     = 1'b0;
        add_en     = 1'b0;
        unit       = '0;
        prod       = '0;
        st         = dttm_pkg::ST_OK;

        if (r_phase != dttm_pkg::PH_DONE) begin
            if (numeric && is_dig) begin
                n_digit = acc_sat;
                n_seen  = 1'b1;
            end else if ((numeric || r_phase == dttm_pkg::PH_FRACTION) && !r_seen && is_ss) begin
                n_pend  = dttm_pkg::ST_SYNTAX;
                n_phase = dttm_pkg::PH_DONE;
            end else begin
                case (r_phase)
                    dttm_pkg::PH_START: begin
                        if (i_byte == dttm_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = dttm_pkg::PH_MINUS;
                        end else if (i_byte == dttm_pkg::CH_P) begin
                            n_phase = dttm_pkg::PH_DATE;
                        end else begin
                            n_pend  = dttm_pkg::ST_SYNTAX;
                            n_phase = dttm_pkg::PH_DONE;
                        end
                    end
                    dttm_pkg::PH_MINUS: begin
                        if (i_byte == dttm_pkg::CH_P) begin
                            n_phase = dttm_pkg::PH_DATE;
                        end else begin
                            n_pend  = dttm_pkg::ST_SYNTAX;
                            n_phase = dttm_pkg::PH_DONE;
                        end
                    end
                    dttm_pkg::PH_DATE: begin
                        if (i_byte == dttm_pkg::CH_Y || i_byte == dttm_pkg::CH_M) begin
                            n_pend  = dttm_pkg::ST_RANGE;
                            n_phase = dttm_pkg::PH_DONE;
                        end else if (i_byte == dttm_pkg::CH_D) begin
                            want_field = 1'b1;
                            lim        = dttm_pkg::LIM_DAY;
                            lim_small  = dttm_pkg::LIM_DAY;
                            unit       = dttm_pkg::MS_PER_DAY;
                            ok_phase   = dttm_pkg::PH_AFTER_D;
                        end else if (r_seen) begin
                            n_pend  = dttm_pkg::ST_SYNTAX;
                            n_phase = dttm_pkg::PH_DONE;
                        end else if (i_byte == dttm_pkg::CH_T) begin
                            n_field = 1'b0;
                            n_phase = dttm_pkg::PH_TIME;
                        end else begin
                            n_phase = dttm_pkg::PH_DONE;
                        end
                    end
                    dttm_pkg::PH_AFTER_D: begin
                        if (i_byte == dttm_pkg::CH_T) begin
                            n_field = 1'b0;
                            n_digit = '0;
                            n_seen  = 1'b0;
                            n_phase = dttm_pkg::PH_TIME;
                        end else begin
                            n_phase = dttm_pkg::PH_DONE;
                        end
                    end
                    dttm_pkg::PH_TIME, dttm_pkg::PH_AFTER_H, dttm_pkg::PH_AFTER_MIN: begin
                        if (r_phase == dttm_pkg::PH_TIME && i_byte == dttm_pkg::CH_H) begin
                            want_field = 1'b1;
                            lim        = dttm_pkg::LIM_HOUR;
                            lim_small  = dttm_pkg::LIM_HOUR2;
                            unit       = dttm_pkg::MS_PER_HOUR;
                            ok_phase   = dttm_pkg::PH_AFTER_H;
                        end else if (r_phase != dttm_pkg::PH_AFTER_MIN &&
                                     i_byte == dttm_pkg::CH_M) begin
                            want_field = 1'b1;
                            lim        = dttm_pkg::LIM_MIN;
                            lim_small  = dttm_pkg::LIM_SIXTY;
                            unit       = dttm_pkg::MS_PER_MIN;
                            ok_phase   = dttm_pkg::PH_AFTER_MIN;
                        end else if (i_byte == dttm_pkg::CH_S || i_byte == dttm_pkg::CH_DOT) begin
                            want_field = 1'b1;
                            lim        = dttm_pkg::LIM_SEC;
                            lim_small  = dttm_pkg::LIM_SIXTY;
                            unit       = dttm_pkg::MS_PER_SEC;
                            ok_phase   = dttm_pkg::PH_DONE;
                            is_sec     = 1'b1;
                        end else if (r_seen) begin
                            n_pend  = dttm_pkg::ST_SYNTAX;
                            n_phase = dttm_pkg::PH_DONE;
                        end else begin
                            n_phase = dttm_pkg::PH_DONE;
                        end
                    end
                    dttm_pkg::PH_FRACTION: begin
                        if (is_dig) begin
                            if (r_fcnt != 2'd3) begin
                                n_digit = acc[DW-1:0];
                                n_fcnt  = r_fcnt + 2'd1;
                            end
                            n_seen = 1'b1;
                        end else if (i_byte == dttm_pkg::CH_S && r_seen) begin
                            // pad short fractions on the right
                            case (r_fcnt)
                                2'd1:    unit = UW'(100);
                                2'd2:    unit = UW'(10);
                                default: unit = UW'(1);
                            endcase
                            add_en  = 1'b1;
                            n_field = 1'b1;
                            n_phase = dttm_pkg::PH_DONE;
                        end else begin
                            n_pend  = dttm_pkg::ST_SYNTAX;
                            n_phase = dttm_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = dttm_pkg::PH_DONE;
                    end
                endcase
            end
        end

        if (want_field) begin
            if (!r_seen) begin
                n_pend  = dttm_pkg::ST_SYNTAX;
                n_phase = dttm_pkg::PH_DONE;
            end else if (r_digit > lim || (r_total != 32'd0 && r_digit > lim_small)) begin
                n_pend  = dttm_pkg::ST_RANGE;
                n_phase = dttm_pkg::PH_DONE;
            end else begin
                add_en  = 1'b1;
                n_field = 1'b1;
                n_digit = '0;
                n_seen  = 1'b0;
                n_phase = ok_phase;
                if (is_sec && i_byte == dttm_pkg::CH_DOT) begin
                    n_field = 1'b0;
                    n_fcnt  = 2'd0;
                    n_phase = dttm_pkg::PH_FRACTION;
                end
            end
        end

        if (add_en) begin
            prod    = r_digit * unit;
            n_total = r_total + prod[31:0];
        end

        // the terminator never adds, so the total and sign are already final
        st = n_pend;
        if (st == dttm_pkg::ST_OK && !n_field) begin
            st = dttm_pkg::ST_SYNTAX;
        end
        o_res_valid       = is_end;
        o_res.status      = dttm_pkg::t_status'(st);
        o_res.duration_ms = '0;
        if (st == dttm_pkg::ST_OK) begin
            o_res.duration_ms = r_neg ? -$signed(r_total) : $signed(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && is_end)) begin
            r_phase <= dttm_pkg::PH_START;
            r_digit <= '0;
            r_seen  <= 1'b0;
            r_fcnt  <= 2'd0;
            r_total <= 32'd0;
            r_neg   <= 1'b0;
            r_field <= 1'b0;
            r_pend  <= dttm_pkg::ST_OK;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_digit <= n_digit;
            r_seen  <= n_seen;
            r_fcnt  <= n_fcnt;
            r_total <= n_total;
            r_neg   <= n_neg;
            r_field <= n_field;
            r_pend  <= n_pend;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/duration_text_to_millis_top.sv =====
// A terminating zero byte passes through the byte register, then the output register, before its result is presented.
// Throughput: one byte per cycle; the byte register keeps taking text while a result
// waits in the output register, and stalls only when a second terminator arrives.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser to
// its start state. Depends on dttm_pkg, dttm_byte_if, dttm_result_if and dttm_parser.
`default_nettype none

module duration_text_to_millis_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dttm_byte_if.sink      i_text,
    dttm_result_if.source  o_result
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    dttm_pkg::t_result r_out;

    logic              adv;
    logic              res_valid;
    dttm_pkg::t_result res;

    // a nonzero byte never produces a result, so it may move on under backpressure
    assign adv = r_in_valid &&
                 (r_in_byte != dttm_pkg::CH_NUL || !r_out_valid || o_result.ready);
    assign i_text.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    dttm_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out.status;
    assign o_result.duration_ms = r_out.duration_ms;

endmodule

`default_nettype wire
